### hw/rtl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Operation and status codes shared by the sorted-list priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int VALUE_W  = 16;
    localparam int PRI_W    = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_PEEK     = 2'd2,
        OP_DECREASE = 2'd3
    } op_t;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADPRI   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTDEC   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

endpackage : spq_pkg
`default_nettype wire

### hw/rtl/stable_priority_queue_decrease_key_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue_decrease_key_top
// Bounded stable priority queue with decrease-key, kept as a sorted list.
//
// Usage: one request enters on in_valid/in_stall with op, value and
// priority_req; exactly one result leaves on out_valid/out_stall with status,
// out_value and out_priority. Entries live in a single-port-write,
// registered-read memory sorted by ascending priority number, equal numbers
// in arrival order. At most one memory write and one read per cycle under
// a small sequencer. A request that fails a check (bad priority, full,
// empty) goes straight to the result; peek reads the head; remove reads
// the head and shifts the remaining entries down; insert moves larger
// entries up into the hole one at a time; decrease key scans from the tail
// for the value, then re-places it as insert does. Each walk step is a read
// state followed by a write or compare state, as the memory port allows.
// The next request is taken in the cycle after the result is loaded.
// in_stall is high while a request is being worked on. The result is held
// in an output register; while the receiver stalls, a new request is still
// taken and worked on, and its result waits until the register frees.
// Reset empties the queue (count only; memory contents are left as they are)
// and drops any pending result.
// ----------------------------------------------------------------------------
module stable_priority_queue_decrease_key_top
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [VALUE_W-1:0]  value,
    input  wire logic [PRI_W-1:0]    priority_req,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [VALUE_W-1:0]       out_value,
    output logic [PRI_W-1:0]         out_priority
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SH_RD,
        S_SH_CMP,
        S_HD_RD,
        S_HD_CAP,
        S_DN_RD,
        S_DN_WR,
        S_FD_RD,
        S_FD_CMP,
        S_PUSH
    } state_t;

    state_t               state_reg;
    op_t                  op_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [PRI_W-1:0]     pri_reg;
    logic [AW-1:0]        idx_reg;
    logic [CW-1:0]        count_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [VALUE_W-1:0]   res_value_reg;
    logic [PRI_W-1:0]     res_pri_reg;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [PRI_W-1:0]     out_pri_reg;

    // Entry storage: one write and one registered read per cycle
    logic [VALUE_W-1:0]   entry_value_reg    [QUEUE_DEPTH];
    logic [PRI_W-1:0]     entry_priority_reg [QUEUE_DEPTH];
    logic [VALUE_W-1:0]   rd_val_reg;
    logic [PRI_W-1:0]     rd_pri_reg;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;
    logic [VALUE_W-1:0]   mem_wval;
    logic [PRI_W-1:0]     mem_wpri;
    logic [CW-1:0]        idx_inc;

    assign idx_inc   = CW'(idx_reg) + CW'(1);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_value = out_value_reg;
    assign out_priority = out_pri_reg;

    // Memory port control: address and data follow the sequencer state
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_raddr = idx_reg;
        mem_wval  = value_reg;
        mem_wpri  = pri_reg;
        case (state_reg)
            S_SH_RD:
            begin
                // hole at the head: drop the new entry straight in
                if (idx_reg == '0)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    mem_raddr = idx_reg - AW'(1);
                end
            end
            S_SH_CMP:
            begin
                mem_we = 1'b1;
                if (rd_pri_reg > pri_reg)
                begin
                    mem_wval = rd_val_reg;
                    mem_wpri = rd_pri_reg;
                end
            end
            S_HD_RD:
            begin
                mem_raddr = '0;
            end
            S_DN_RD:
            begin
                mem_raddr = idx_reg + AW'(1);
            end
            S_DN_WR:
            begin
                mem_we   = 1'b1;
                mem_wval = rd_val_reg;
                mem_wpri = rd_pri_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_val_reg <= entry_value_reg[mem_raddr];
        rd_pri_reg <= entry_priority_reg[mem_raddr];
        if (mem_we)
        begin
            entry_value_reg[mem_waddr]    <= mem_wval;
            entry_priority_reg[mem_waddr] <= mem_wpri;
        end
    end

    // Sequencer, count and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_INSERT;
            value_reg      <= '0;
            pri_reg        <= '0;
            idx_reg        <= '0;
            count_reg      <= '0;
            res_status_reg <= ST_OK;
            res_value_reg  <= '0;
            res_pri_reg    <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            out_value_reg  <= '0;
            out_pri_reg    <= '0;
        end
        else
        begin
            // drop a taken result, unless a new one is loaded this cycle
            if (out_valid_reg && !out_stall && (state_reg != S_PUSH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg         <= op_t'(op);
                        value_reg      <= value;
                        pri_reg        <= priority_req;
                        res_status_reg <= ST_OK;
                        res_value_reg  <= '0;
                        res_pri_reg    <= '0;
                        case (op_t'(op))
                            OP_INSERT:
                            begin
                                if (priority_req == '0)
                                begin
                                    res_status_reg <= ST_BADPRI;
                                    state_reg      <= S_PUSH;
                                end
                                else if (count_reg >= DEPTH_C)
                                begin
                                    res_status_reg <= ST_FULL;
                                    state_reg      <= S_PUSH;
                                end
                                else
                                begin
                                    idx_reg   <= AW'(count_reg);
                                    state_reg <= S_SH_RD;
                                end
                            end
                            OP_REMOVE, OP_PEEK:
                            begin
                                if (count_reg == '0)
                                begin
                                    res_status_reg <= ST_EMPTY;
                                    state_reg      <= S_PUSH;
                                end
                                else
                                begin
                                    state_reg <= S_HD_RD;
                                end
                            end
                            default:
                            begin
                                if (priority_req == '0)
                                begin
                                    res_status_reg <= ST_BADPRI;
                                    state_reg      <= S_PUSH;
                                end
                                else if (count_reg == '0)
                                begin
                                    res_status_reg <= ST_NOTFOUND;
                                    state_reg      <= S_PUSH;
                                end
                                else
                                begin
                                    idx_reg   <= AW'(count_reg - CW'(1));
                                    state_reg <= S_FD_RD;
                                end
                            end
                        endcase
                    end
                end
                S_SH_RD:
                begin
                    if (idx_reg == '0)
                    begin
                        if (op_reg == OP_INSERT)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        state_reg <= S_PUSH;
                    end
                    else
                    begin
                        state_reg <= S_SH_CMP;
                    end
                end
                S_SH_CMP:
                begin
                    // move the larger entry up into the hole, else settle
                    if (rd_pri_reg > pri_reg)
                    begin
                        idx_reg   <= idx_reg - AW'(1);
                        state_reg <= S_SH_RD;
                    end
                    else
                    begin
                        if (op_reg == OP_INSERT)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        state_reg <= S_PUSH;
                    end
                end
                S_HD_RD:
                begin
                    state_reg <= S_HD_CAP;
                end
                S_HD_CAP:
                begin
                    res_value_reg <= rd_val_reg;
                    res_pri_reg   <= rd_pri_reg;
                    idx_reg       <= '0;
                    state_reg     <= (op_reg == OP_PEEK) ? S_PUSH : S_DN_RD;
                end
                S_DN_RD:
                begin
                    if (idx_inc >= count_reg)
                    begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_PUSH;
                    end
                    else
                    begin
                        state_reg <= S_DN_WR;
                    end
                end
                S_DN_WR:
                begin
                    idx_reg   <= idx_reg + AW'(1);
                    state_reg <= S_DN_RD;
                end
                S_FD_RD:
                begin
                    state_reg <= S_FD_CMP;
                end
                S_FD_CMP:
                begin
                    if (rd_val_reg == value_reg)
                    begin
                        if (rd_pri_reg <= pri_reg)
                        begin
                            res_status_reg <= ST_NOTDEC;
                            state_reg      <= S_PUSH;
                        end
                        else
                        begin
                            // the match becomes the hole; re-place from there
                            state_reg <= S_SH_RD;
                        end
                    end
                    else if (idx_reg == '0)
                    begin
                        res_status_reg <= ST_NOTFOUND;
                        state_reg      <= S_PUSH;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - AW'(1);
                        state_reg <= S_FD_RD;
                    end
                end
                S_PUSH:
                begin
                    // hold the result until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_reg;
                        out_value_reg <= res_value_reg;
                        out_pri_reg   <= res_pri_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above queue depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CW'(1))
        || (count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count moved by more than one");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != S_IDLE) && (state_reg != S_PUSH))
        else $error("memory written outside a walk");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(status_reg)))
        else $error("stalled result lost or changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) |-> (res_status_reg <= ST_FULL))
        else $error("result status out of range");
`endif

endmodule : stable_priority_queue_decrease_key_top
`default_nettype wire
